// ===== rtl/core/imufd_pkg.sv =====
// ----------------------------------------------------------------------------
// imufd_pkg
// Types and constants shared by the inertial sensor frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imufd_pkg;

  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic [7:0]  HEADER_RESET    = 8'h55;
  localparam logic [15:0] THRESHOLD_RESET = 16'd61895;

  // configuration register indexes
  localparam logic [7:0] REG_FRAME_HEADER   = 8'd0;
  localparam logic [7:0] REG_JUMP_THRESHOLD = 8'd1;

  // frame type bytes
  localparam logic [7:0] TYPE_FIRST = 8'h51;
  localparam logic [7:0] TYPE_LAST  = 8'h59;

  // scale factors to Q16.16
  localparam logic signed [17:0] SCALE_ACCEL = 18'sd32;
  localparam logic signed [17:0] SCALE_RATE  = 18'sd4000;
  localparam logic signed [17:0] SCALE_ANGLE = 18'sd360;
  localparam logic signed [17:0] SCALE_MAG   = 18'sd65536;
  localparam logic signed [17:0] SCALE_QUAT  = 18'sd2;

  localparam logic signed [17:0] FULL_TURN = 18'sd65536;

  typedef enum logic [3:0] {
    KIND_ACCEL    = 4'd0,
    KIND_RATE     = 4'd1,
    KIND_ANGLE    = 4'd2,
    KIND_MAG      = 4'd3,
    KIND_PORT     = 4'd4,
    KIND_PRESSURE = 4'd5,
    KIND_POSITION = 4'd6,
    KIND_GPS      = 4'd7,
    KIND_QUAT     = 4'd8,
    KIND_UNKNOWN  = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_PLUS  = 2'd2,
    MODE_MINUS = 2'd3
  } unwrap_mode_e;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [63:0] payload;     // byte 0 in the low bits
  } frame_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic signed [31:0] value_w;
    logic signed [31:0] word_a;
    logic signed [31:0] word_b;
    logic signed [17:0] expanded_yaw;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/imufd_front.sv =====
// ----------------------------------------------------------------------------
// imufd_front
// Byte-level frame assembly with header sync and a two-entry frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

module imufd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        frame_header_i,
  input  wire logic              push_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   full_o,
  output logic                   frame_valid_o,
  output imufd_pkg::frame_t      frame_o,
  input  wire logic              frame_pop_i
);

  localparam logic [imufd_pkg::POS_W-1:0] POS_IDLE = '0;
  localparam logic [imufd_pkg::POS_W-1:0] POS_TYPE = imufd_pkg::POS_W'(1);
  localparam logic [imufd_pkg::POS_W-1:0] POS_LAST =
    imufd_pkg::POS_W'(imufd_pkg::FRAME_LEN - 1);

  logic [imufd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                  type_q;
  logic [63:0]                 payload_q;
  logic [2:0]                  slot;
  logic                        accept;
  logic                        enq;

  imufd_pkg::frame_t entry_q [imufd_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       deq;

  assign full_o        = (cnt_q == 2'(imufd_pkg::QUEUE_DEPTH));
  assign accept        = push_i && !full_o;
  assign enq           = accept && (pos_q == POS_LAST);
  assign deq           = frame_pop_i && frame_valid_o;
  assign frame_valid_o = (cnt_q != 2'd0);
  assign frame_o       = entry_q[rd_ptr_q];

  logic [imufd_pkg::POS_W-1:0] pos_off;
  assign pos_off = pos_q - imufd_pkg::POS_W'(2);
  assign slot    = pos_off[2:0];

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      priority if (pos_q == POS_IDLE) begin
        // resync: wait for the header byte
        if (rx_byte_i == frame_header_i) pos_d = POS_TYPE;
      end else if (pos_q == POS_LAST) begin
        pos_d = POS_IDLE;
      end else begin
        pos_d = pos_q + POS_TYPE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_IDLE;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      pos_q <= pos_d;
      if (enq) wr_ptr_q <= !wr_ptr_q;
      if (deq) rd_ptr_q <= !rd_ptr_q;
      unique case ({enq, deq})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q == POS_TYPE) type_q <= rx_byte_i;
    if (accept && pos_q > POS_TYPE && pos_q < POS_LAST) begin
      payload_q[slot*8 +: 8] <= rx_byte_i;
    end
    if (enq) begin
      entry_q[wr_ptr_q].frame_type <= type_q;
      entry_q[wr_ptr_q].payload    <= payload_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/imufd_back.sv =====
// ----------------------------------------------------------------------------
// imufd_back
// Frame decode, Q16.16 scaling, yaw unwrap and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module imufd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       jump_threshold_i,
  input  wire logic              frame_valid_i,
  input  imufd_pkg::frame_t      frame_i,
  output logic                   frame_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output imufd_pkg::result_t     result_o
);

  imufd_pkg::result_t entry_q [imufd_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       full, deq;

  imufd_pkg::unwrap_mode_e mode_q, mode_d;
  logic signed [15:0]      last_yaw_q;
  logic signed [17:0]      held_q, held_d;

  imufd_pkg::kind_e   kind;
  imufd_pkg::result_t res;
  logic signed [15:0] h0, h1, h2, h3;
  logic signed [17:0] scale;
  logic signed [33:0] p0, p1, p2;
  logic               use_scale;
  logic signed [17:0] d, thr;
  logic               neg_jump, pos_jump;

  assign full        = (cnt_q == 2'(imufd_pkg::QUEUE_DEPTH));
  assign frame_pop_o = frame_valid_i && !full;
  assign empty_o     = (cnt_q == 2'd0);
  assign deq         = pop_i && !empty_o;
  assign result_o    = entry_q[rd_ptr_q];

  assign h0 = frame_i.payload[15:0];
  assign h1 = frame_i.payload[31:16];
  assign h2 = frame_i.payload[47:32];
  assign h3 = frame_i.payload[63:48];

  always_comb begin
    if (frame_i.frame_type >= imufd_pkg::TYPE_FIRST &&
        frame_i.frame_type <= imufd_pkg::TYPE_LAST) begin
      kind = imufd_pkg::kind_e'(4'(frame_i.frame_type - imufd_pkg::TYPE_FIRST));
    end else begin
      kind = imufd_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    use_scale = 1'b1;
    unique case (kind)
      imufd_pkg::KIND_ACCEL: scale = imufd_pkg::SCALE_ACCEL;
      imufd_pkg::KIND_RATE:  scale = imufd_pkg::SCALE_RATE;
      imufd_pkg::KIND_ANGLE: scale = imufd_pkg::SCALE_ANGLE;
      imufd_pkg::KIND_MAG:   scale = imufd_pkg::SCALE_MAG;
      imufd_pkg::KIND_QUAT:  scale = imufd_pkg::SCALE_QUAT;
      default: begin
        scale     = '0;
        use_scale = 1'b0;
      end
    endcase
  end

  assign p0 = 34'(h0) * 34'(scale);
  assign p1 = 34'(h1) * 34'(scale);
  assign p2 = 34'(h2) * 34'(scale);

  // yaw tracker, step measured against the previous raw yaw
  assign d        = 18'(h2) - 18'(last_yaw_q);
  assign thr      = {2'b00, jump_threshold_i};
  assign neg_jump = (d < -thr);
  assign pos_jump = (d > thr);

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    if (kind == imufd_pkg::KIND_ANGLE) begin
      priority if (mode_q == imufd_pkg::MODE_FIRST) begin
        mode_d = imufd_pkg::MODE_NORMAL;
        held_d = 18'(h2);
      end else if (neg_jump || mode_q == imufd_pkg::MODE_PLUS) begin
        if (pos_jump) begin
          mode_d = imufd_pkg::MODE_NORMAL;
        end else begin
          mode_d = imufd_pkg::MODE_PLUS;
          held_d = 18'(h2) + imufd_pkg::FULL_TURN;
        end
      end else if (pos_jump || mode_q == imufd_pkg::MODE_MINUS) begin
        if (neg_jump) begin
          mode_d = imufd_pkg::MODE_PLUS;
        end else begin
          mode_d = imufd_pkg::MODE_MINUS;
          held_d = 18'(h2) - imufd_pkg::FULL_TURN;
        end
      end else begin
        mode_d = imufd_pkg::MODE_NORMAL;
        held_d = 18'(h2);
      end
    end
  end

  always_comb begin
    res              = '0;
    res.kind         = kind;
    res.expanded_yaw = held_d;
    if (use_scale) begin
      res.value_x = p0[31:0];
      res.value_y = p1[31:0];
      res.value_z = p2[31:0];
    end
    if (kind == imufd_pkg::KIND_QUAT) res.value_w = {{15{h3[15]}}, h3, 1'b0};
    if (kind == imufd_pkg::KIND_PRESSURE || kind == imufd_pkg::KIND_POSITION) begin
      res.word_a = frame_i.payload[31:0];
      res.word_b = frame_i.payload[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= imufd_pkg::MODE_FIRST;
      last_yaw_q <= '0;
      held_q     <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (frame_pop_o) begin
        mode_q <= mode_d;
        held_q <= held_d;
        if (kind == imufd_pkg::KIND_ANGLE) last_yaw_q <= h2;
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) rd_ptr_q <= !rd_ptr_q;
      unique case ({frame_pop_o, deq})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_pop_o) entry_q[wr_ptr_q] <= res;
  end

endmodule

`default_nettype wire

// ===== rtl/core/imu_frame_decoder_yaw_unwrap_unit.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decoder_yaw_unwrap_unit
// Inertial sensor serial frame decoder with Q16.16 scaling and yaw unwrap.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the frame queue is not full; one result per
// 11-byte frame. A frame's last byte transfer writes it to the frame queue;
// the back end decodes one queued frame per cycle into the output queue while that queue is not full.
// Reset (async, active low) returns to header search, restores the header and
// threshold registers, clears the yaw tracker and empties both queues.
`default_nettype none

module imu_frame_decoder_yaw_unwrap_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [3:0]              kind_o,
  output logic signed [31:0]      value_x_o,
  output logic signed [31:0]      value_y_o,
  output logic signed [31:0]      value_z_o,
  output logic signed [31:0]      value_w_o,
  output logic signed [31:0]      word_a_o,
  output logic signed [31:0]      word_b_o,
  output logic signed [17:0]      expanded_yaw_o
);

  logic [7:0]  frame_header_q;
  logic [15:0] jump_threshold_q;
  logic        cfg_we;

  logic               frame_valid, frame_pop;
  imufd_pkg::frame_t  frame;
  imufd_pkg::result_t result;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_header_q   <= imufd_pkg::HEADER_RESET;
      jump_threshold_q <= imufd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index_i == imufd_pkg::REG_FRAME_HEADER) frame_header_q <= cfg_data_i[7:0];
      if (cfg_index_i == imufd_pkg::REG_JUMP_THRESHOLD) jump_threshold_q <= cfg_data_i;
    end
  end

  imufd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_header_i (frame_header_q),
    .push_i         (push),
    .rx_byte_i      (rx_byte_i),
    .full_o         (full),
    .frame_valid_o  (frame_valid),
    .frame_o        (frame),
    .frame_pop_i    (frame_pop)
  );

  imufd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .jump_threshold_i (jump_threshold_q),
    .frame_valid_i    (frame_valid),
    .frame_i          (frame),
    .frame_pop_o      (frame_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .result_o         (result)
  );

  assign kind_o         = result.kind;
  assign value_x_o      = result.value_x;
  assign value_y_o      = result.value_y;
  assign value_z_o      = result.value_z;
  assign value_w_o      = result.value_w;
  assign word_a_o       = result.word_a;
  assign word_b_o       = result.word_b;
  assign expanded_yaw_o = result.expanded_yaw;

endmodule

`default_nettype wire

// ===== test/imufd_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imufd_frame_checker
// Watches the byte, register and result channels of the frame decoder, keeps
// its own copy of the frame assembler and yaw tracker, and compares every
// popped result field by field with the oldest decoded frame still owed.
// ----------------------------------------------------------------------------

module imufd_frame_checker
  import imufd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic signed [31:0] value_w_i,
  input  logic signed [31:0] word_a_i,
  input  logic signed [31:0] word_b_i,
  input  logic signed [17:0] expanded_yaw_i,
  output int                 pending_o,
  output int                 errors_o,
  output int                 frames_o,
  output int                 wraps_o
);

  localparam longint ACCEL_GAIN = 32;
  localparam longint RATE_GAIN  = 4000;
  localparam longint ANGLE_GAIN = 360;
  localparam longint MAG_GAIN   = 65536;
  localparam longint QUAT_GAIN  = 2;
  localparam int     TURN       = 65536;
  localparam int     MAX_PRINTED = 50;

  logic [7:0]         header_reg;
  logic [15:0]        threshold_reg;
  int unsigned        byte_pos;
  logic [7:0]         frame_type;
  logic [7:0]         payload [8];
  logic signed [15:0] last_yaw;
  unwrap_mode_e       yaw_mode;
  logic signed [17:0] held_yaw;
  result_t            decoded_frames_q [$];

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors_o < MAX_PRINTED)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
    errors_o++;
  endtask

  task automatic unwrap_yaw(input logic signed [15:0] yaw);
    int d;
    int thr;
    d = int'(yaw) - int'(last_yaw);
    thr = int'(threshold_reg);
    if (yaw_mode == MODE_FIRST) begin
      yaw_mode = MODE_NORMAL;
      held_yaw = yaw;
    end else if (d < -thr || yaw_mode == MODE_PLUS) begin
      if (d > thr) begin
        yaw_mode = MODE_NORMAL;
      end else begin
        if (yaw_mode != MODE_PLUS) wraps_o++;
        yaw_mode = MODE_PLUS;
        held_yaw = 18'(int'(yaw) + TURN);
      end
    end else if (d > thr || yaw_mode == MODE_MINUS) begin
      if (d < -thr) begin
        yaw_mode = MODE_PLUS;
      end else begin
        if (yaw_mode != MODE_MINUS) wraps_o++;
        yaw_mode = MODE_MINUS;
        held_yaw = 18'(int'(yaw) - TURN);
      end
    end else begin
      yaw_mode = MODE_NORMAL;
      held_yaw = yaw;
    end
    last_yaw = yaw;
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    result_t            r;
    longint             gain;
    logic signed [15:0] halves [4];
    if (byte_pos == 0) begin
      if (b == header_reg) byte_pos = 1;
      return;
    end
    if (byte_pos == 1) begin
      frame_type = b;
      byte_pos = 2;
      return;
    end
    if (byte_pos < FRAME_LEN - 1) begin
      payload[byte_pos - 2] = b;
      byte_pos++;
      return;
    end
    // checksum byte closes the frame, its value is not looked at
    byte_pos = 0;
    for (int i = 0; i < 4; i++) halves[i] = {payload[2 * i + 1], payload[2 * i]};
    r = '0;
    if (frame_type >= TYPE_FIRST && frame_type <= TYPE_LAST)
      r.kind = kind_e'(4'(frame_type - TYPE_FIRST));
    else
      r.kind = KIND_UNKNOWN;
    gain = 0;
    case (r.kind)
      KIND_ACCEL: gain = ACCEL_GAIN;
      KIND_RATE:  gain = RATE_GAIN;
      KIND_ANGLE: gain = ANGLE_GAIN;
      KIND_MAG:   gain = MAG_GAIN;
      KIND_QUAT:  gain = QUAT_GAIN;
      KIND_PRESSURE, KIND_POSITION: begin
        r.word_a = {payload[3], payload[2], payload[1], payload[0]};
        r.word_b = {payload[7], payload[6], payload[5], payload[4]};
      end
      default: ;
    endcase
    r.value_x = 32'(longint'(halves[0]) * gain);
    r.value_y = 32'(longint'(halves[1]) * gain);
    r.value_z = 32'(longint'(halves[2]) * gain);
    if (r.kind == KIND_QUAT) r.value_w = 32'(longint'(halves[3]) * gain);
    if (r.kind == KIND_ANGLE) unwrap_yaw(halves[2]);
    r.expanded_yaw = held_yaw;
    decoded_frames_q.push_back(r);
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_frames_q.size() == 0) begin
      flag_mismatch("result with nothing owed", 32'(kind_i), '0);
      return;
    end
    want = decoded_frames_q.pop_front();
    frames_o++;
    if (kind_i !== want.kind) flag_mismatch("kind", 32'(kind_i), 32'(want.kind));
    if (value_x_i !== want.value_x) flag_mismatch("value_x", value_x_i, want.value_x);
    if (value_y_i !== want.value_y) flag_mismatch("value_y", value_y_i, want.value_y);
    if (value_z_i !== want.value_z) flag_mismatch("value_z", value_z_i, want.value_z);
    if (value_w_i !== want.value_w) flag_mismatch("value_w", value_w_i, want.value_w);
    if (word_a_i !== want.word_a) flag_mismatch("word_a", word_a_i, want.word_a);
    if (word_b_i !== want.word_b) flag_mismatch("word_b", word_b_i, want.word_b);
    if (expanded_yaw_i !== want.expanded_yaw)
      flag_mismatch("expanded_yaw", 32'(expanded_yaw_i), 32'(want.expanded_yaw));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_reg    = HEADER_RESET;
      threshold_reg = THRESHOLD_RESET;
      byte_pos      = 0;
      frame_type    = '0;
      for (int i = 0; i < 8; i++) payload[i] = '0;
      last_yaw      = '0;
      yaw_mode      = MODE_FIRST;
      held_yaw      = '0;
      decoded_frames_q.delete();
      pending_o     = 0;
      errors_o      = 0;
      frames_o      = 0;
      wraps_o       = 0;
    end else begin
      if (pop_i && !empty_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_HEADER:   header_reg = cfg_data_i[7:0];
          REG_JUMP_THRESHOLD: threshold_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) decode_rx_byte(rx_byte_i);
      pending_o = decoded_frames_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes into the frame decoder: directed frames of every kind
// and yaw wrap, then mostly well-formed random frames mixed with noise and cut
// frames, under several header and threshold settings and random stalls.
// ----------------------------------------------------------------------------

module testbench;
  import imufd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 5;
  localparam int PHASE_BYTES = 300;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 400;

  localparam logic [7:0] TYPE_ACCEL    = 8'h51;
  localparam logic [7:0] TYPE_RATE     = 8'h52;
  localparam logic [7:0] TYPE_ANGLE    = 8'h53;
  localparam logic [7:0] TYPE_MAG      = 8'h54;
  localparam logic [7:0] TYPE_PORT     = 8'h55;
  localparam logic [7:0] TYPE_PRESSURE = 8'h56;
  localparam logic [7:0] TYPE_POSITION = 8'h57;
  localparam logic [7:0] TYPE_GPS      = 8'h58;
  localparam logic [7:0] TYPE_QUAT     = 8'h59;
  localparam logic [7:0] TYPE_BELOW    = 8'h50;
  localparam logic [7:0] TYPE_ABOVE    = 8'h5A;

  // indexes past the register file, writes there must be dropped
  localparam logic [7:0] REG_PAST_END = 8'd2;
  localparam logic [7:0] REG_ALL_ONES = 8'hFF;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        empty;
  logic        pop;
  logic [3:0]  kind;
  logic signed [31:0] value_x, value_y, value_z, value_w, word_a, word_b;
  logic signed [17:0] expanded_yaw;

  int frames_pending, check_errors, frames_checked, yaw_wraps;

  logic [7:0]  cur_header;
  logic [15:0] recent_yaw;
  logic        tx_burst;
  int          bytes_sent;
  int          reg_writes;
  int          hold_req;

  imu_frame_decoder_yaw_unwrap_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind),
    .value_x_o      (value_x),
    .value_y_o      (value_y),
    .value_z_o      (value_z),
    .value_w_o      (value_w),
    .word_a_o       (word_a),
    .word_b_o       (word_b),
    .expanded_yaw_o (expanded_yaw)
  );

  imufd_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push_i         (push),
    .full_i         (full),
    .rx_byte_i      (rx_byte),
    .empty_i        (empty),
    .pop_i          (pop),
    .kind_i         (kind),
    .value_x_i      (value_x),
    .value_y_i      (value_y),
    .value_z_i      (value_z),
    .value_w_i      (value_w),
    .word_a_i       (word_a),
    .word_b_i       (word_b),
    .expanded_yaw_i (expanded_yaw),
    .pending_o      (frames_pending),
    .errors_o       (check_errors),
    .frames_o       (frames_checked),
    .wraps_o        (yaw_wraps)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL imu_frame_decoder_yaw_unwrap_unit");
    $finish;
  end

  // result side: random pop gaps, gap-free stretches, and long holds on request
  initial begin : result_drain
    int  gap;
    int  hold_done;
    logic rx_fast;
    hold_done = 0;
    rx_fast = 1'b0;
    pop = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_fast = ~rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 4);
      if (hold_req != hold_done) begin
        gap = LONG_HOLD;
        hold_done++;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_byte <= b;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] body);
    send_byte(cur_header);
    send_byte(ftype);
    for (int i = 0; i < 8; i++) send_byte(body[8 * i +: 8]);
    send_byte(8'($urandom));
  endtask

  task automatic send_angle(input logic [15:0] yaw);
    send_frame(TYPE_ANGLE, {16'($urandom), yaw, 32'($urandom)});
    recent_yaw = yaw;
  endtask

  function automatic logic [15:0] next_yaw();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'h7FFF - 16'($urandom_range(0, 800));
      2: return 16'h8000 + 16'($urandom_range(0, 800));
      default: return recent_yaw + 16'($urandom_range(0, 2000)) - 16'd1000;
    endcase
  endfunction

  task automatic send_random_frame();
    int         pick;
    logic [7:0] ftype;
    pick = $urandom_range(0, 99);
    if (pick < 30) ftype = TYPE_ANGLE;
    else if (pick < 85) ftype = 8'(TYPE_FIRST + $urandom_range(0, 8));
    else ftype = 8'($urandom);
    if (ftype == TYPE_ANGLE) send_angle(next_yaw());
    else send_frame(ftype, {$urandom, $urandom});
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_HEADER) cur_header = data[7:0];
    reg_writes++;
    @(negedge clk_i);
  endtask

  // stop offering bytes until every owed frame is out, then let the pipe settle
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (frames_pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int   phase_start;
    logic paused;
    rst_ni     = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    push       = 1'b0;
    rx_byte    = '0;
    cur_header = HEADER_RESET;
    recent_yaw = '0;
    tx_burst   = 1'b0;
    bytes_sent = 0;
    reg_writes = 0;
    hold_req   = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // junk ahead of the first header is dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h54);
    // first angle frame only echoes its yaw
    send_angle(16'h7FFF);
    send_angle(16'h8000);   // wrap down, plus one turn
    send_angle(16'h8300);   // stays in plus mode
    send_angle(16'h7D00);   // jump back, held yaw kept
    send_angle(16'h0000);
    send_angle(16'h8300);
    send_angle(16'h7FFF);   // wrap up, minus one turn
    send_angle(16'h7D00);
    send_angle(16'h8000);   // from minus straight to plus
    send_angle(16'h7FFF);
    send_frame(TYPE_ACCEL, {16'h8000, 16'h0000, 16'h8000, 16'h7FFF});
    send_frame(TYPE_RATE, {16'h1234, 16'hFFFF, 16'h7FFF, 16'h8000});
    send_frame(TYPE_MAG, {16'h0000, 16'h0001, 16'h7FFF, 16'h8000});
    send_frame(TYPE_QUAT, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001});
    send_frame(TYPE_PRESSURE, {32'h8000_0000, 32'h7FFF_FFFF});
    send_frame(TYPE_POSITION, {32'h0155_55AA, 32'hFFFF_FFFF});
    // header value as type and payload is plain data
    send_frame(TYPE_PORT, 64'h5555_5555_5555_5555);
    send_frame(TYPE_GPS, {$urandom, $urandom});
    send_frame(8'h00, {$urandom, $urandom});
    send_frame(8'hFF, {$urandom, $urandom});
    send_frame(TYPE_BELOW, {$urandom, $urandom});
    send_frame(TYPE_ABOVE, {$urandom, $urandom});

    for (int p = 1; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        1: begin
          write_reg(REG_FRAME_HEADER, 16'h0000);
          write_reg(REG_JUMP_THRESHOLD, 16'h0000);
        end
        2: begin
          write_reg(REG_FRAME_HEADER, 16'hFFFF);
          write_reg(REG_JUMP_THRESHOLD, 16'hFFFF);
        end
        3: begin
          write_reg(REG_FRAME_HEADER, 16'($urandom));
          write_reg(REG_JUMP_THRESHOLD, 16'($urandom));
          write_reg(REG_PAST_END, 16'($urandom));
          write_reg(REG_ALL_ONES, 16'($urandom));
        end
        default: begin
          write_reg(REG_FRAME_HEADER, {8'hAA, HEADER_RESET});
          write_reg(REG_JUMP_THRESHOLD, THRESHOLD_RESET);
        end
      endcase
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
          1: begin
            // cut frame: the bytes that follow finish it as data
            send_byte(cur_header);
            repeat ($urandom_range(1, 9)) send_byte(8'($urandom));
          end
          default: send_random_frame();
        endcase
        if (!paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          paused = 1'b1;
          if (p % 2 == 1) hold_req++;
          else drain_results();
        end
      end
    end

    drain_results();
    repeat (20) @(negedge clk_i);
    $display("run: %0d bytes under %0d register writes, %0d frames compared",
             bytes_sent, reg_writes, frames_checked);
    $display("yaw tracker entered a wrap mode %0d times, %0d mismatches",
             yaw_wraps, check_errors);
    if (check_errors == 0 && frames_pending == 0) begin
      $display("PASS imu_frame_decoder_yaw_unwrap_unit");
    end else begin
      $display("FAIL imu_frame_decoder_yaw_unwrap_unit");
    end
    $finish;
  end

endmodule

// ===== imu_frame_decoder_yaw_unwrap_unit.f =====
rtl/core/imufd_pkg.sv
rtl/core/imufd_front.sv
rtl/core/imufd_back.sv
rtl/core/imu_frame_decoder_yaw_unwrap_unit.sv
test/imufd_frame_checker.sv
test/testbench.sv
